// File: hdl/cdll_pkg.sv
// Package for the cursor doubly linked list: sizes, index types, operation codes
// and the structs that run between the sequencer and the top level.
// Depends on nothing.
package cdll_pkg;

    localparam int NODES  = 64;
    localparam int IDX_W  = $clog2(NODES + 1);
    localparam int ADDR_W = $clog2(NODES);
    localparam int VAL_W  = 32;
    localparam int OP_W   = 5;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic signed [VAL_W-1:0]  vword_t;
    typedef logic [OP_W-1:0]          opcode_t;

    localparam idx_t NIL = idx_t'(NODES);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 5'd0,
        OP_INS_FIRST = 5'd1,
        OP_INS_LAST  = 5'd2,
        OP_TO_FIRST  = 5'd3,
        OP_TO_LAST   = 5'd4,
        OP_RD_FIRST  = 5'd5,
        OP_RD_LAST   = 5'd6,
        OP_DEL_FIRST = 5'd7,
        OP_DEL_LAST  = 5'd8,
        OP_POST_DEL  = 5'd9,
        OP_PRE_DEL   = 5'd10,
        OP_POST_INS  = 5'd11,
        OP_PRE_INS   = 5'd12,
        OP_RD_CURSOR = 5'd13,
        OP_OVERWRITE = 5'd14,
        OP_NEXT      = 5'd15,
        OP_PREV      = 5'd16
    } op_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        idx_t  data;
    } link_wr_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        vword_t data;
    } value_wr_t;

    typedef struct packed {
        vword_t read_value;
        logic   read_valid;
        logic   error;
        logic   cursor_active;
    } result_t;

    function automatic logic is_node(idx_t x);
        return x < NIL;
    endfunction

    function automatic addr_t to_addr(idx_t x);
        return x[ADDR_W-1:0];
    endfunction

endpackage

// File: hdl/cursor_doubly_linked_list_top.sv
// Top level of the cursor doubly linked list: the sequencer, the value and link
// memories and the result output register. Depends on cdll_pkg, cdll_ram, cdll_ctrl.
//
// Usage. Each input word carries one list operation and a value; each accepted
// word gives exactly one result word. Both channels use valid and stall: a word
// moves at a rising edge where valid is high and stall is low.
// The input word passes the sequencer states S_RD2, S_EXE and S_FIN and then the
// output register before its result is valid; a new word is taken only in S_IDLE.
// S_IDLE reads the node links at the cursor, head, tail or free pointer, S_RD2
// follows one link further or reads at the free pointer, S_EXE writes the primary
// node entries and S_FIN the neighbour links and hands the result to the output
// register; each link memory has one write port, hence the split writes.
// Reset clears the list, the cursor and the free pool; the node memories are
// not cleared and need no clearing pass, so words are taken straight after reset.
// When the receiver stalls, the result is held in the output register and the
// block finishes its next operation up to the point of handing over its result,
// then holds the input stalled until the output register frees.
module cursor_doubly_linked_list_top
    import cdll_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  opcode_t operation,
    input  vword_t  value,
    output logic    result_valid,
    input  logic    result_stall,
    output vword_t  read_value,
    output logic    read_valid,
    output logic    error,
    output logic    cursor_active
);

    addr_t     rd_addr;
    idx_t      left_rdata, right_rdata;
    vword_t    value_rdata;
    link_wr_t  left_wr, right_wr;
    value_wr_t value_wr;
    logic      res_valid, res_ready;
    result_t   res;
    logic      result_valid_reg;
    result_t   out_reg;

    cdll_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .operation   (operation),
        .value       (value),
        .rd_addr     (rd_addr),
        .left_rdata  (left_rdata),
        .right_rdata (right_rdata),
        .value_rdata (value_rdata),
        .left_wr     (left_wr),
        .right_wr    (right_wr),
        .value_wr    (value_wr),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    cdll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_left_ram (
        .clk     (clk),
        .wr_en   (left_wr.en),
        .wr_addr (left_wr.addr),
        .wr_data (left_wr.data),
        .rd_addr (rd_addr),
        .rd_data (left_rdata)
    );

    cdll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_right_ram (
        .clk     (clk),
        .wr_en   (right_wr.en),
        .wr_addr (right_wr.addr),
        .wr_data (right_wr.data),
        .rd_addr (rd_addr),
        .rd_data (right_rdata)
    );

    cdll_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_value_ram (
        .clk     (clk),
        .wr_en   (value_wr.en),
        .wr_addr (value_wr.addr),
        .wr_data (value_wr.data),
        .rd_addr (rd_addr),
        .rd_data (value_rdata)
    );

    assign res_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result_valid  = result_valid_reg;
    assign read_value    = out_reg.read_value;
    assign read_valid    = out_reg.read_valid;
    assign error         = out_reg.error;
    assign cursor_active = out_reg.cursor_active;

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> !res_valid ##1 !res_valid)
        else $error("result offered too soon after an input word");

    a_read_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(read_valid && error))
        else $error("result flags both a read and an error");

    a_zero_when_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !read_valid) |-> (read_value == '0))
        else $error("read value not zero on a word without a read");

    a_busy_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> item_stall)
        else $error("input taken while a result is pending in the sequencer");

endmodule

// File: hdl/cdll_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/cdll_ctrl.sv
// Operation sequencer: list pointers, free pool bookkeeping and the read and
// write schedule for the value and link memories. Depends on cdll_pkg.
module cdll_ctrl
    import cdll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  opcode_t   operation,
    input  vword_t    value,
    output addr_t     rd_addr,
    input  idx_t      left_rdata,
    input  idx_t      right_rdata,
    input  vword_t    value_rdata,
    output link_wr_t  left_wr,
    output link_wr_t  right_wr,
    output value_wr_t value_wr,
    output logic      res_valid,
    input  logic      res_ready,
    output result_t   res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD2  = 4'b0010,
        S_EXE  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    opcode_t   op_reg;
    vword_t    val_reg;
    idx_t      head_reg, head_next;
    idx_t      tail_reg, tail_next;
    idx_t      cur_reg, cur_next;
    idx_t      free_reg, free_next;
    idx_t      fresh_reg, fresh_next;
    idx_t      l1_reg, r1_reg;
    vword_t    v1_reg;
    link_wr_t  left_w2_reg, left_w2_next;
    link_wr_t  right_w2_reg, right_w2_next;
    result_t   res_reg, res_next;
    link_wr_t  left_w1, right_w1;
    value_wr_t value_w1;

    logic act, take_ok, do_link, do_unlink;
    idx_t new_node, free_take, fresh_take;
    idx_t lk_l, lk_r, um, ul_l, ul_r;

    assign item_stall = (state_reg != S_IDLE);
    assign res_valid  = (state_reg == S_FIN);
    assign res        = res_reg;
    assign act        = is_node(cur_reg);

    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                case (operation)
                    OP_INS_FIRST, OP_INS_LAST: rd_addr = to_addr(free_reg);
                    OP_RD_FIRST, OP_DEL_FIRST: rd_addr = to_addr(head_reg);
                    OP_RD_LAST, OP_DEL_LAST:   rd_addr = to_addr(tail_reg);
                    default:                   rd_addr = to_addr(cur_reg);
                endcase
            end
            S_RD2:
            begin
                case (op_reg)
                    OP_POST_DEL: rd_addr = to_addr(right_rdata);
                    OP_PRE_DEL:  rd_addr = to_addr(left_rdata);
                    default:     rd_addr = to_addr(free_reg);
                endcase
            end
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        left_w1       = '0;
        right_w1      = '0;
        value_w1      = '0;
        left_w2_next  = '0;
        right_w2_next = '0;
        res_next      = '0;

        take_ok    = 1'b0;
        new_node   = NIL;
        free_take  = free_reg;
        fresh_take = fresh_reg;
        if (is_node(free_reg))
        begin
            take_ok   = 1'b1;
            new_node  = free_reg;
            free_take = right_rdata;
        end
        else if (is_node(fresh_reg))
        begin
            take_ok    = 1'b1;
            new_node   = fresh_reg;
            fresh_take = fresh_reg + idx_t'(1);
        end

        do_link   = 1'b0;
        lk_l      = NIL;
        lk_r      = NIL;
        do_unlink = 1'b0;
        um        = NIL;
        ul_l      = NIL;
        ul_r      = NIL;

        case (op_reg)
            OP_CLEAR:
            begin
                head_next  = NIL;
                tail_next  = NIL;
                cur_next   = NIL;
                free_next  = NIL;
                fresh_next = '0;
            end
            OP_INS_FIRST:
            begin
                do_link = 1'b1;
                lk_r    = head_reg;
            end
            OP_INS_LAST:
            begin
                do_link = 1'b1;
                lk_l    = tail_reg;
            end
            OP_POST_INS:
            begin
                do_link = act;
                lk_l    = cur_reg;
                lk_r    = r1_reg;
            end
            OP_PRE_INS:
            begin
                do_link = act;
                lk_l    = l1_reg;
                lk_r    = cur_reg;
            end
            OP_TO_FIRST: cur_next = head_reg;
            OP_TO_LAST:  cur_next = tail_reg;
            OP_RD_FIRST, OP_RD_LAST:
            begin
                if (!is_node(head_reg))
                begin
                    res_next.error = 1'b1;
                end
                else
                begin
                    res_next.read_value = v1_reg;
                    res_next.read_valid = 1'b1;
                end
            end
            OP_RD_CURSOR:
            begin
                if (!act)
                begin
                    res_next.error = 1'b1;
                end
                else
                begin
                    res_next.read_value = v1_reg;
                    res_next.read_valid = 1'b1;
                end
            end
            OP_DEL_FIRST:
            begin
                do_unlink = is_node(head_reg);
                um        = head_reg;
                ul_l      = l1_reg;
                ul_r      = r1_reg;
            end
            OP_DEL_LAST:
            begin
                do_unlink = is_node(tail_reg);
                um        = tail_reg;
                ul_l      = l1_reg;
                ul_r      = r1_reg;
            end
            OP_POST_DEL:
            begin
                do_unlink = act && (cur_reg != tail_reg);
                um        = r1_reg;
                ul_l      = left_rdata;
                ul_r      = right_rdata;
            end
            OP_PRE_DEL:
            begin
                do_unlink = act && (cur_reg != head_reg);
                um        = l1_reg;
                ul_l      = left_rdata;
                ul_r      = right_rdata;
            end
            OP_OVERWRITE:
            begin
                value_w1.en   = act;
                value_w1.addr = to_addr(cur_reg);
                value_w1.data = val_reg;
            end
            OP_NEXT:
            begin
                if (act)
                begin
                    cur_next = r1_reg;
                end
            end
            OP_PREV:
            begin
                if (act)
                begin
                    cur_next = l1_reg;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        if (do_link)
        begin
            if (!take_ok)
            begin
                res_next.error = 1'b1;
            end
            else
            begin
                free_next     = free_take;
                fresh_next    = fresh_take;
                value_w1.en   = 1'b1;
                value_w1.addr = to_addr(new_node);
                value_w1.data = val_reg;
                left_w1.en    = 1'b1;
                left_w1.addr  = to_addr(new_node);
                left_w1.data  = lk_l;
                right_w1.en   = 1'b1;
                right_w1.addr = to_addr(new_node);
                right_w1.data = lk_r;
                if (is_node(lk_l))
                begin
                    right_w2_next.en   = 1'b1;
                    right_w2_next.addr = to_addr(lk_l);
                    right_w2_next.data = new_node;
                end
                else
                begin
                    head_next = new_node;
                end
                if (is_node(lk_r))
                begin
                    left_w2_next.en   = 1'b1;
                    left_w2_next.addr = to_addr(lk_r);
                    left_w2_next.data = new_node;
                end
                else
                begin
                    tail_next = new_node;
                end
            end
        end

        if (do_unlink)
        begin
            if (is_node(ul_l))
            begin
                right_w1.en   = 1'b1;
                right_w1.addr = to_addr(ul_l);
                right_w1.data = ul_r;
            end
            else
            begin
                head_next = ul_r;
            end
            if (is_node(ul_r))
            begin
                left_w1.en   = 1'b1;
                left_w1.addr = to_addr(ul_r);
                left_w1.data = ul_l;
            end
            else
            begin
                tail_next = ul_l;
            end
            if (cur_reg == um)
            begin
                cur_next = NIL;
            end
            free_next          = um;
            right_w2_next.en   = 1'b1;
            right_w2_next.addr = to_addr(um);
            right_w2_next.data = free_reg;
        end

        res_next.cursor_active = is_node(cur_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_RD2;
                end
            end
            S_RD2: state_next = S_EXE;
            S_EXE: state_next = S_FIN;
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        left_wr  = '0;
        right_wr = '0;
        value_wr = '0;
        if (state_reg == S_EXE)
        begin
            left_wr  = left_w1;
            right_wr = right_w1;
            value_wr = value_w1;
        end
        else if (state_reg == S_FIN)
        begin
            left_wr  = left_w2_reg;
            right_wr = right_w2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= NIL;
            tail_reg     <= NIL;
            cur_reg      <= NIL;
            free_reg     <= NIL;
            fresh_reg    <= '0;
            left_w2_reg  <= '0;
            right_w2_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXE)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                cur_reg      <= cur_next;
                free_reg     <= free_next;
                fresh_reg    <= fresh_next;
                left_w2_reg  <= left_w2_next;
                right_w2_reg <= right_w2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
        if (state_reg == S_RD2)
        begin
            l1_reg <= left_rdata;
            r1_reg <= right_rdata;
            v1_reg <= value_rdata;
        end
        if (state_reg == S_EXE)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for cursor_doubly_linked_list_top: it predicts every result word
// from its own model of the list and compares each word that the block hands over.
// Depends on cdll_pkg and the RTL of the block; it needs no files or arguments.
module tb_top
    import cdll_pkg::*;
();

    localparam opcode_t OP_SPARE_LO     = 5'd17;
    localparam opcode_t OP_SPARE_HI     = 5'd31;
    localparam int      WATCHDOG_CYCLES = 300000;
    localparam int      RANDOM_WORDS    = 660;
    localparam int      REPORT_LIMIT    = 10;

    typedef struct {
        result_t res;
        opcode_t op;
        int      seq;
    } pending_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    opcode_t operation    = '0;
    vword_t  value        = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    vword_t  read_value;
    logic    read_valid;
    logic    error;
    logic    cursor_active;

    vword_t  node_data [NODES];
    idx_t    prev_link [NODES];
    idx_t    next_link [NODES];
    idx_t    first_ptr;
    idx_t    last_ptr;
    idx_t    cur_ptr;
    idx_t    free_ptr;
    idx_t    fresh_cnt;
    int      list_len;
    int      peak_len;

    pending_t  expected_q[$];
    int        words_sent;
    int        words_checked;
    int        mismatches;
    int        err_results;
    int        full_inserts;
    bit [31:0] ops_seen;
    bit        no_idle;
    int        hold_req;
    int        hold_left;
    int        cycles;

    cursor_doubly_linked_list_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .value         (value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .read_value    (read_value),
        .read_valid    (read_valid),
        .error         (error),
        .cursor_active (cursor_active)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > WATCHDOG_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic idx_t left_of(idx_t n);
        return (n < NIL) ? prev_link[n[ADDR_W-1:0]] : NIL;
    endfunction

    function automatic idx_t right_of(idx_t n);
        return (n < NIL) ? next_link[n[ADDR_W-1:0]] : NIL;
    endfunction

    function automatic void empty_list();
        first_ptr = NIL;
        last_ptr  = NIL;
        cur_ptr   = NIL;
        free_ptr  = NIL;
        fresh_cnt = '0;
        list_len  = 0;
    endfunction

    function automatic idx_t grab_node(vword_t v);
        idx_t n;
        if (free_ptr < NIL)
        begin
            n        = free_ptr;
            free_ptr = next_link[n[ADDR_W-1:0]];
        end
        else if (fresh_cnt < NIL)
        begin
            n         = fresh_cnt;
            fresh_cnt = fresh_cnt + 1'b1;
        end
        else
        begin
            full_inserts++;
            return NIL;
        end
        node_data[n[ADDR_W-1:0]] = v;
        list_len++;
        if (list_len > peak_len)
            peak_len = list_len;
        return n;
    endfunction

    function automatic void splice_in(idx_t n, idx_t l, idx_t r);
        prev_link[n[ADDR_W-1:0]] = l;
        next_link[n[ADDR_W-1:0]] = r;
        if (l < NIL)
            next_link[l[ADDR_W-1:0]] = n;
        else
            first_ptr = n;
        if (r < NIL)
            prev_link[r[ADDR_W-1:0]] = n;
        else
            last_ptr = n;
    endfunction

    function automatic void drop_node(idx_t n);
        idx_t l;
        idx_t r;
        l = left_of(n);
        r = right_of(n);
        if (l < NIL)
            next_link[l[ADDR_W-1:0]] = r;
        else
            first_ptr = r;
        if (r < NIL)
            prev_link[r[ADDR_W-1:0]] = l;
        else
            last_ptr = l;
        if (cur_ptr == n)
            cur_ptr = NIL;
        if (n < NIL)
        begin
            next_link[n[ADDR_W-1:0]] = free_ptr;
            free_ptr = n;
            list_len--;
        end
    endfunction

    function automatic result_t apply_op(opcode_t op, vword_t val);
        result_t r;
        idx_t    n;
        logic    act;
        r   = '0;
        act = cur_ptr < NIL;
        case (op)
            OP_CLEAR:
                empty_list();
            OP_INS_FIRST, OP_INS_LAST:
            begin
                n = grab_node(val);
                if (n == NIL)
                    r.error = 1'b1;
                else if (op == OP_INS_FIRST)
                    splice_in(n, NIL, first_ptr);
                else
                    splice_in(n, last_ptr, NIL);
            end
            OP_TO_FIRST:
                cur_ptr = first_ptr;
            OP_TO_LAST:
                cur_ptr = last_ptr;
            OP_RD_FIRST, OP_RD_LAST:
            begin
                if (first_ptr >= NIL)
                    r.error = 1'b1;
                else
                begin
                    n = (op == OP_RD_FIRST) ? first_ptr : last_ptr;
                    r.read_value = node_data[n[ADDR_W-1:0]];
                    r.read_valid = 1'b1;
                end
            end
            OP_DEL_FIRST:
                if (first_ptr < NIL)
                    drop_node(first_ptr);
            OP_DEL_LAST:
                if (last_ptr < NIL)
                    drop_node(last_ptr);
            OP_POST_DEL:
                if (act && cur_ptr != last_ptr)
                    drop_node(right_of(cur_ptr));
            OP_PRE_DEL:
                if (act && cur_ptr != first_ptr)
                    drop_node(left_of(cur_ptr));
            OP_POST_INS, OP_PRE_INS:
            begin
                if (act)
                begin
                    n = grab_node(val);
                    if (n == NIL)
                        r.error = 1'b1;
                    else if (op == OP_POST_INS)
                        splice_in(n, cur_ptr, right_of(cur_ptr));
                    else
                        splice_in(n, left_of(cur_ptr), cur_ptr);
                end
            end
            OP_RD_CURSOR:
            begin
                if (!act)
                    r.error = 1'b1;
                else
                begin
                    r.read_value = node_data[cur_ptr[ADDR_W-1:0]];
                    r.read_valid = 1'b1;
                end
            end
            OP_OVERWRITE:
                if (act)
                    node_data[cur_ptr[ADDR_W-1:0]] = val;
            OP_NEXT:
                if (act)
                    cur_ptr = right_of(cur_ptr);
            OP_PREV:
                if (act)
                    cur_ptr = left_of(cur_ptr);
            default:
                ;
        endcase
        r.cursor_active = cur_ptr < NIL;
        return r;
    endfunction

    function automatic vword_t pick_value();
        case ($urandom_range(0, 11))
            0:       return vword_t'(32'h7FFF_FFFF);
            1:       return vword_t'(32'h8000_0000);
            2:       return vword_t'(32'h0000_0000);
            3:       return vword_t'(32'hFFFF_FFFF);
            default: return vword_t'($urandom);
        endcase
    endfunction

    // Operations are weighted so that the list grows towards a moving target length
    // and the cursor is usually active, which keeps the cursor operations meaningful.
    function automatic opcode_t pick_op(bit grow);
        int p;
        int ins;
        int del;
        p   = $urandom_range(0, 99);
        ins = grow ? 30 : 10;
        del = grow ? 8 : 25;
        if (p < 1 && !grow)
            return OP_CLEAR;
        if (p < 4)
            return opcode_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        p -= 4;
        if (p < ins)
        begin
            case ($urandom_range(0, 3))
                0:       return OP_INS_FIRST;
                1:       return OP_INS_LAST;
                2:       return OP_POST_INS;
                default: return OP_PRE_INS;
            endcase
        end
        p -= ins;
        if (p < del)
        begin
            case ($urandom_range(0, 3))
                0:       return OP_DEL_FIRST;
                1:       return OP_DEL_LAST;
                2:       return OP_POST_DEL;
                default: return OP_PRE_DEL;
            endcase
        end
        p -= del;
        if (p < 22)
        begin
            case ($urandom_range(0, 3))
                0:       return OP_TO_FIRST;
                1:       return OP_TO_LAST;
                2:       return OP_NEXT;
                default: return OP_PREV;
            endcase
        end
        p -= 22;
        if (p < 15)
        begin
            case ($urandom_range(0, 2))
                0:       return OP_RD_FIRST;
                1:       return OP_RD_LAST;
                default: return OP_RD_CURSOR;
            endcase
        end
        p -= 15;
        if (p < 6)
            return OP_OVERWRITE;
        return opcode_t'($urandom_range(OP_CLEAR, OP_PREV));
    endfunction

    // Called at a rising edge; returns at the rising edge where the word is taken.
    task automatic send_word(input opcode_t op, input vword_t val);
        bit       taken;
        pending_t p;
        if (!no_idle)
            while ($urandom_range(0, 99) < 11)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid <= 1'b1;
        operation  <= op;
        value      <= val;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            if (taken)
            begin
                p.res = apply_op(op, val);
                p.op  = op;
                p.seq = words_sent;
                expected_q.push_back(p);
                words_sent++;
                ops_seen[op] = 1'b1;
                if (p.res.error)
                    err_results++;
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !no_idle && ($urandom_range(0, 99) < 11);
    end

    // Inputs change only at rising edges, so the values at the falling edge are the
    // ones that the next rising edge will act on.
    always @(negedge clk)
    begin : check_result
        pending_t p;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result word: value %0d valid %0b error %0b active %0b",
                             read_value, read_valid, error, cursor_active);
            end
            else
            begin
                p = expected_q.pop_front();
                words_checked++;
                if (read_value !== p.res.read_value || read_valid !== p.res.read_valid ||
                    error !== p.res.error || cursor_active !== p.res.cursor_active)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display(
                            "Mismatch on word %0d (operation %0d): expected value %0d",
                            p.seq, p.op, p.res.read_value);
                        $display(
                            "  valid %0b error %0b active %0b, got value %0d",
                            p.res.read_valid, p.res.error, p.res.cursor_active,
                            read_value);
                        $display(
                            "  valid %0b error %0b active %0b",
                            read_valid, error, cursor_active);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_word(OP_RD_FIRST, pick_value());
        send_word(OP_RD_LAST, pick_value());
        send_word(OP_RD_CURSOR, pick_value());
        send_word(OP_DEL_FIRST, pick_value());
        send_word(OP_POST_INS, vword_t'(32'h1111_1111));
        send_word(OP_NEXT, pick_value());
        send_word(OP_INS_FIRST, vword_t'(32'h7FFF_FFFF));
        send_word(OP_INS_LAST, vword_t'(32'h8000_0000));
        send_word(OP_INS_FIRST, vword_t'(32'h0000_0000));
        send_word(OP_INS_LAST, vword_t'(32'hFFFF_FFFF));
        send_word(OP_TO_FIRST, pick_value());
        send_word(OP_RD_CURSOR, pick_value());
        send_word(OP_PRE_DEL, pick_value());
        send_word(OP_POST_INS, vword_t'(32'h5A5A_5A5A));
        send_word(OP_NEXT, pick_value());
        send_word(OP_PRE_INS, vword_t'(32'h1234_5678));
        send_word(OP_OVERWRITE, vword_t'(32'hA5A5_A5A5));
        send_word(OP_RD_FIRST, pick_value());
        send_word(OP_RD_LAST, pick_value());
        send_word(OP_TO_LAST, pick_value());
        send_word(OP_POST_DEL, pick_value());
        send_word(OP_NEXT, pick_value());
        send_word(OP_TO_LAST, pick_value());
        send_word(OP_PREV, pick_value());
        send_word(OP_POST_DEL, pick_value());
        send_word(OP_PRE_DEL, pick_value());
        send_word(OP_TO_FIRST, pick_value());
        send_word(OP_DEL_FIRST, pick_value());
        send_word(OP_SPARE_HI, pick_value());
        send_word(OP_SPARE_LO, pick_value());
        send_word(OP_DEL_LAST, pick_value());
        send_word(OP_CLEAR, pick_value());
        wait_drained();
    endtask

    task automatic test_pool_full();
        send_word(OP_CLEAR, pick_value());
        for (int i = 0; i < NODES; i++)
            send_word(OP_INS_LAST, pick_value());
        send_word(OP_INS_FIRST, pick_value());
        send_word(OP_TO_FIRST, pick_value());
        send_word(OP_POST_INS, pick_value());
        send_word(OP_PRE_INS, pick_value());
        send_word(OP_DEL_LAST, pick_value());
        send_word(OP_INS_FIRST, pick_value());
        send_word(OP_RD_FIRST, pick_value());
        send_word(OP_DEL_FIRST, pick_value());
        send_word(OP_RD_CURSOR, pick_value());
        send_word(OP_CLEAR, pick_value());
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req = 80;
        no_idle  = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(pick_op(1'b1), pick_value());
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int target;
        target = 8;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                target = $urandom_range(0, NODES + 6);
            no_idle = (i >= 300 && i < 450);
            send_word(pick_op(list_len < target), pick_value());
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        empty_list();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random();
        repeat (10) @(posedge clk);
        $display("Sent %0d words using %0d distinct operation codes; peak list length %0d.",
                 words_sent, $countones(ops_seen), peak_len);
        $display("Checked %0d results: %0d errors, %0d refused inserts, %0d mismatches.",
                 words_checked, err_results, full_inserts, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
